/* hw/rtl/gmf_pkg.sv */
package gmf_pkg;

    // Register field widths.
    localparam int RADIUS_W = 3;
    localparam int DIM_W    = 11;
    localparam int PIX_W    = 8;

    // APB port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Value of a pixel that lies outside the kernel mask.
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;

    // Register map, by word index.
    typedef enum logic [1:0] {
        REG_RADIUS        = 2'd0,
        REG_DISC_SHAPE    = 2'd1,
        REG_PADDED_WIDTH  = 2'd2,
        REG_PADDED_HEIGHT = 2'd3
    } gmf_reg_t;

    // Per-pixel flags handed from the front to the back.
    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } gmf_flags_t;

    // True when offset (dx, dy) from the window corner lies inside the disc of radius r.
    function automatic logic in_disc(input logic [4:0] r, input logic [4:0] dx,
                                     input logic [4:0] dy);
        logic [4:0] ax;
        logic [4:0] ay;
        logic [9:0] sx;
        logic [9:0] sy;
        logic [9:0] rr;
        ax = (dx > r) ? (dx - r) : (r - dx);
        ay = (dy > r) ? (dy - r) : (r - dy);
        sx = {5'b0, ax} * {5'b0, ax};
        sy = {5'b0, ay} * {5'b0, ay};
        rr = {5'b0, r} * {5'b0, r};
        return (sx + sy) <= rr;
    endfunction

endpackage

/* hw/rtl/grayscale_min_filter.sv */
// A pixel passes the line stores, the front stage, the queue, the window and the
// reduction and output registers. Throughput: one pixel per cycle unless stalled,
// set by line stores that take one write and one registered read per cycle and by
// the registered compare tree; pixels outside the output window give no result.
// Reset: position returns to column 0 of row 0 and the registers take their
// defaults (radius 1, disc kernel, 1024 by 1024); line store contents stay undefined.
module grayscale_min_filter
    import gmf_pkg::*;
#(
    parameter int MAX_RADIUS        = 7,
    parameter int MAX_PADDED_WIDTH  = 1024,
    parameter int MAX_PADDED_HEIGHT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      min_value,
    output logic                  row_end,
    output logic                  frame_end
);

    localparam int S  = 2 * MAX_RADIUS + 1;
    localparam int CW = $clog2(MAX_PADDED_WIDTH + 1);
    localparam int RW = $clog2(MAX_PADDED_HEIGHT + 1);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int QW = $bits(gmf_flags_t) + S * PIX_W;

    logic [RADIUS_W-1:0] radius_reg;
    logic                disc_shape_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    logic                cfg_we;
    gmf_reg_t            reg_sel;
    logic [4:0]          r_eff;
    logic [CW-1:0]       w_eff;
    logic [RW-1:0]       h_eff;

    logic                push;
    logic [S-1:0][PIX_W-1:0] push_col;
    gmf_flags_t          push_flags;
    logic                pop;
    logic                q_empty;
    logic [LW-1:0]       q_level;
    logic [QW-1:0]       q_data;
    logic [S-1:0][PIX_W-1:0] q_col;
    gmf_flags_t          q_flags;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = gmf_reg_t'(paddr[3:2]);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_W'(1);
            disc_shape_reg <= 1'b1;
            width_reg <= DIM_W'(1024);
            height_reg <= DIM_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                REG_RADIUS:        radius_reg <= pwdata[RADIUS_W-1:0];
                REG_DISC_SHAPE:    disc_shape_reg <= pwdata[0];
                REG_PADDED_WIDTH:  width_reg <= pwdata[DIM_W-1:0];
                REG_PADDED_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_sel)
            REG_RADIUS:        prdata = APB_DATA_W'(radius_reg);
            REG_DISC_SHAPE:    prdata = APB_DATA_W'(disc_shape_reg);
            REG_PADDED_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_PADDED_HEIGHT: prdata = APB_DATA_W'(height_reg);
        endcase
    end

    // Effective radius and image size after saturation.
    always_comb
    begin
        r_eff = (5'(radius_reg) > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : 5'(radius_reg);

        if (width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(width_reg) > MAX_PADDED_WIDTH)
        begin
            w_eff = CW'(MAX_PADDED_WIDTH);
        end
        else
        begin
            w_eff = CW'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = RW'(1);
        end
        else if (32'(height_reg) > MAX_PADDED_HEIGHT)
        begin
            h_eff = RW'(MAX_PADDED_HEIGHT);
        end
        else
        begin
            h_eff = RW'(height_reg);
        end
    end

    gmf_front #(
        .MAX_RADIUS        (MAX_RADIUS),
        .MAX_PADDED_WIDTH  (MAX_PADDED_WIDTH),
        .MAX_PADDED_HEIGHT (MAX_PADDED_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .r_eff       (r_eff),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .queue_level (q_level),
        .push        (push),
        .push_col    (push_col),
        .push_flags  (push_flags)
    );

    gmf_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_flags, push_col}),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .level     (q_level)
    );

    assign q_col   = q_data[S*PIX_W-1:0];
    assign q_flags = gmf_flags_t'(q_data[QW-1:S*PIX_W]);

    gmf_back #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_col      (q_col),
        .q_flags    (q_flags),
        .pop        (pop),
        .r_eff      (r_eff),
        .disc_shape (disc_shape_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .min_value  (min_value),
        .row_end    (row_end),
        .frame_end  (frame_end)
    );

endmodule

/* hw/rtl/gmf_ram.sv */
module gmf_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; a read at the written
    // address returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/gmf_front.sv */
module gmf_front
    import gmf_pkg::*;
#(
    parameter int MAX_RADIUS        = 7,
    parameter int MAX_PADDED_WIDTH  = 1024,
    parameter int MAX_PADDED_HEIGHT = 1024,
    parameter int S   = 2 * MAX_RADIUS + 1,
    parameter int CW  = $clog2(MAX_PADDED_WIDTH + 1),
    parameter int RW  = $clog2(MAX_PADDED_HEIGHT + 1),
    parameter int LW  = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [PIX_W-1:0]          pixel,
    input  logic                      frame_start,
    input  logic [4:0]                r_eff,
    input  logic [CW-1:0]             w_eff,
    input  logic [RW-1:0]             h_eff,
    input  logic [LW-1:0]             queue_level,
    output logic                      push,
    output logic [S-1:0][PIX_W-1:0]   push_col,
    output gmf_flags_t                push_flags
);

    localparam int SW = (S > 1) ? $clog2(S) : 1;
    localparam int AW = $clog2(MAX_PADDED_WIDTH);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] slot_reg, slot_next;

    logic          accept;
    logic [CW-1:0] c;
    logic [RW-1:0] rw;
    logic [SW-1:0] sl;
    logic [5:0]    span;
    gmf_flags_t    flags;

    logic             f1_valid_reg;
    logic [SW-1:0]    f1_slot_reg;
    logic [PIX_W-1:0] f1_pix_reg;
    gmf_flags_t       f1_flags_reg;

    logic [PIX_W-1:0] rdata [S];

    // Hold off while the queue plus the transfer in flight could fill it.
    assign in_stall = (32'(queue_level) + 32'(f1_valid_reg)) >= QUEUE_DEPTH;
    assign accept   = in_valid && !in_stall;
    assign span     = {r_eff, 1'b0};

    // Position of this pixel and of the next one.
    always_comb
    begin
        c = col_reg;
        rw = row_reg;
        sl = slot_reg;
        if (frame_start)
        begin
            c = '0;
            rw = '0;
            sl = '0;
        end
        if (c >= w_eff)
        begin
            c = '0;
            rw = rw + 1'b1;
            sl = (32'(sl) == S - 1) ? '0 : sl + 1'b1;
        end
        if (rw >= h_eff)
        begin
            rw = '0;
            sl = '0;
        end

        flags.emit      = (32'(c) >= 32'(span)) && (32'(rw) >= 32'(span));
        flags.row_end   = (c == w_eff - 1'b1);
        flags.frame_end = flags.row_end && (rw == h_eff - 1'b1);

        col_next = c + 1'b1;
        row_next = rw;
        slot_next = sl;
        if (col_next >= w_eff)
        begin
            col_next = '0;
            row_next = rw + 1'b1;
            slot_next = (32'(sl) == S - 1) ? '0 : sl + 1'b1;
            if (row_next >= h_eff)
            begin
                row_next = '0;
                slot_next = '0;
            end
        end
    end

    // Position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            slot_reg <= slot_next;
        end
    end

    // One line store per row slot; every slot is read at this column.
    for (genvar k = 0; k < S; k++)
    begin : g_line
        gmf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_PADDED_WIDTH)
        ) u_ram (
            .clk   (clk),
            .we    (accept && (32'(sl) == k)),
            .waddr (c[AW-1:0]),
            .wdata (pixel),
            .re    (accept),
            .raddr (c[AW-1:0]),
            .rdata (rdata[k])
        );
    end

    // Stage that lines up with the registered store read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_slot_reg <= sl;
            f1_pix_reg <= pixel;
            f1_flags_reg <= flags;
        end
    end

    // Order the column from the current row upward.
    always_comb
    begin
        push_col[0] = f1_pix_reg;
        for (int dy = 1; dy < S; dy++)
        begin
            if (32'(f1_slot_reg) >= dy)
            begin
                push_col[dy] = rdata[SW'(32'(f1_slot_reg) - dy)];
            end
            else
            begin
                push_col[dy] = rdata[SW'(32'(f1_slot_reg) + S - dy)];
            end
        end
    end

    assign push       = f1_valid_reg;
    assign push_flags = f1_flags_reg;

endmodule

/* hw/rtl/gmf_queue.sv */
module gmf_queue
    import gmf_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int LW     = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty,
    output logic [LW-1:0]     level
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] store [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [LW-1:0]     level_reg;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = store[rd_ptr_reg];
    assign empty    = (level_reg == '0);
    assign level    = level_reg;

endmodule

/* hw/rtl/gmf_back.sv */
module gmf_back
    import gmf_pkg::*;
#(
    parameter int MAX_RADIUS = 7,
    parameter int S = 2 * MAX_RADIUS + 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  logic [S-1:0][PIX_W-1:0] q_col,
    input  gmf_flags_t              q_flags,
    output logic                    pop,
    input  logic [4:0]              r_eff,
    input  logic                    disc_shape,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [PIX_W-1:0]        min_value,
    output logic                    row_end,
    output logic                    frame_end
);

    localparam int G = (S + 3) / 4;

    logic             adv;
    logic [5:0]       span;
    logic             mask_reg [S][S];
    logic [PIX_W-1:0] win_reg [S][S];

    logic             b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg;
    gmf_flags_t       b1_flags_reg, b2_flags_reg, b3_flags_reg, b4_flags_reg;
    logic [PIX_W-1:0] a_reg [S][G];
    logic [PIX_W-1:0] row_min_reg [S];
    logic [PIX_W-1:0] b_reg [G];

    logic [PIX_W-1:0] a_next [S][G];
    logic [PIX_W-1:0] row_min_next [S];
    logic [PIX_W-1:0] b_next [G];
    logic [PIX_W-1:0] min_next;

    logic             out_valid_reg;
    logic [PIX_W-1:0] min_value_reg;
    logic             row_end_reg;
    logic             frame_end_reg;

    // The whole back pipeline moves when the output register can take a transfer.
    assign adv  = !out_valid_reg || !out_stall;
    assign pop  = adv && !q_empty;
    assign span = {r_eff, 1'b0};

    // Kernel mask; it follows the configuration, which the user must keep steady while items flow (not enforced here).
    always_ff @(posedge clk)
    begin
        for (int dy = 0; dy < S; dy++)
        begin
            for (int dx = 0; dx < S; dx++)
            begin
                mask_reg[dy][dx] <= (dx <= 32'(span)) && (dy <= 32'(span))
                    && (!disc_shape || in_disc(r_eff, 5'(dx), 5'(dy)));
            end
        end
    end

    // Window of the last S columns, newest in column zero.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int dy = 0; dy < S; dy++)
            begin
                win_reg[0][dy] <= q_col[dy];
            end
            for (int k = 1; k < S; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    // Minimum over groups of four columns in each row.
    always_comb
    begin
        for (int dy = 0; dy < S; dy++)
        begin
            for (int g = 0; g < G; g++)
            begin
                a_next[dy][g] = PIX_MAX;
                for (int j = 0; j < 4; j++)
                begin
                    if (4 * g + j < S)
                    begin
                        if (mask_reg[dy][4*g+j] && (win_reg[4*g+j][dy] < a_next[dy][g]))
                        begin
                            a_next[dy][g] = win_reg[4*g+j][dy];
                        end
                    end
                end
            end
        end
    end

    // Minimum over the groups of each row.
    always_comb
    begin
        for (int dy = 0; dy < S; dy++)
        begin
            row_min_next[dy] = PIX_MAX;
            for (int g = 0; g < G; g++)
            begin
                if (a_reg[dy][g] < row_min_next[dy])
                begin
                    row_min_next[dy] = a_reg[dy][g];
                end
            end
        end
    end

    // Minimum over groups of four rows.
    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            b_next[g] = PIX_MAX;
            for (int j = 0; j < 4; j++)
            begin
                if ((4 * g + j < S) && (row_min_reg[4*g+j] < b_next[g]))
                begin
                    b_next[g] = row_min_reg[4*g+j];
                end
            end
        end
    end

    // Final minimum.
    always_comb
    begin
        min_next = PIX_MAX;
        for (int g = 0; g < G; g++)
        begin
            if (b_reg[g] < min_next)
            begin
                min_next = b_reg[g];
            end
        end
    end

    // Valid bits of the reduction stages and of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg <= pop && q_flags.emit;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            out_valid_reg <= b4_valid_reg;
        end
    end

    // Data of the reduction stages and of the output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_flags_reg <= q_flags;
            b2_flags_reg <= b1_flags_reg;
            b3_flags_reg <= b2_flags_reg;
            b4_flags_reg <= b3_flags_reg;
            a_reg <= a_next;
            row_min_reg <= row_min_next;
            b_reg <= b_next;
            min_value_reg <= min_next;
            row_end_reg <= b4_flags_reg.row_end;
            frame_end_reg <= b4_flags_reg.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_value = min_value_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

/* tb/tb_grayscale_min_filter.sv */
module tb_grayscale_min_filter;
    import gmf_pkg::*;

    localparam int STORE_ROWS = 15;
    localparam int MAX_R      = 7;
    localparam int MAX_DIM    = 1024;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [PIX_W-1:0] min_value;
        logic             row_end;
        logic             frame_end;
    } erosion_result_t;

    // Scoreboard: predicts the eroded pixel stream and checks it in order.
    class erosion_scoreboard;
        logic [PIX_W-1:0] rows [STORE_ROWS][MAX_DIM];
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned radius;
        int unsigned disc;
        int unsigned width;
        int unsigned height;
        erosion_result_t pending_q[$];
        int errors;
        int results_seen;

        function new();
            col_pos = 0;
            row_pos = 0;
            radius = 1;
            disc = 1;
            width = 1024;
            height = 1024;
            errors = 0;
            results_seen = 0;
        endfunction

        function void set_reg(gmf_reg_t idx, int unsigned value);
            case (idx)
                REG_RADIUS:        radius = value & 7;
                REG_DISC_SHAPE:    disc = value & 1;
                REG_PADDED_WIDTH:  width = value & 11'h7ff;
                REG_PADDED_HEIGHT: height = value & 11'h7ff;
                default: ;
            endcase
        endfunction

        static function int unsigned clamp_dim(int unsigned v);
            if (v == 0)
                return 1;
            return (v > MAX_DIM) ? MAX_DIM : v;
        endfunction

        // Notes one pixel transfer and queues the window minimum it completes.
        function void note_pixel(logic [PIX_W-1:0] pix, bit fs);
            int unsigned r;
            int unsigned w;
            int unsigned h;
            int unsigned slot;
            int unsigned srow;
            int kx;
            int ky;
            logic [PIX_W-1:0] best;
            erosion_result_t res;
            r = (radius > MAX_R) ? MAX_R : radius;
            w = clamp_dim(width);
            h = clamp_dim(height);
            if (fs)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h)
                row_pos = 0;
            slot = row_pos % STORE_ROWS;
            rows[slot][col_pos] = pix;
            if (col_pos >= 2 * r && row_pos >= 2 * r)
            begin
                best = PIX_MAX;
                for (int dy = 0; dy <= 2 * r; dy++)
                begin
                    srow = (slot + STORE_ROWS - dy) % STORE_ROWS;
                    ky = int'(r) - dy;
                    for (int dx = 0; dx <= 2 * r; dx++)
                    begin
                        kx = int'(r) - dx;
                        if (disc != 0 && kx * kx + ky * ky > int'(r * r))
                            continue;
                        if (rows[srow][col_pos - dx] < best)
                            best = rows[srow][col_pos - dx];
                    end
                end
                res.min_value = best;
                res.row_end = (col_pos == w - 1);
                res.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
                pending_q.push_back(res);
            end
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h)
                    row_pos = 0;
            end
        endfunction

        // Compares one result transfer with the oldest prediction.
        function void check_result(logic [PIX_W-1:0] mv, logic re, logic fe);
            erosion_result_t exp_res;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: min_value %0d row_end %0b frame_end %0b", mv, re, fe);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (mv !== exp_res.min_value)
            begin
                $error("min_value: expected %0d, got %0d", exp_res.min_value, mv);
                errors++;
            end
            if (re !== exp_res.row_end)
            begin
                $error("row_end: expected %0b, got %0b", exp_res.row_end, re);
                errors++;
            end
            if (fe !== exp_res.frame_end)
            begin
                $error("frame_end: expected %0b, got %0b", exp_res.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_stall;
    logic [PIX_W-1:0]      min_value;
    logic                  row_end;
    logic                  frame_end;

    erosion_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int idle_cycles;
    int pixels_sent;
    int frames_sent;

    grayscale_min_filter dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
        .frame_start(frame_start),
        .out_valid(out_valid), .out_stall(out_stall), .min_value(min_value),
        .row_end(row_end), .frame_end(frame_end)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: random stall at each falling edge, or one long hold when asked.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            out_stall = 1'b1;
            repeat (300) @(negedge clk);
            hold_request = 1'b0;
        end
        out_stall = ($urandom_range(99) < recv_idle_pct);
    end

    // Result monitor and stall watchdog.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(min_value, row_end, frame_end);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(gmf_reg_t idx, int unsigned value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Waits for the pipeline to drain, then writes all four registers.
    task automatic configure(int unsigned r, int unsigned d, int unsigned w, int unsigned h);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
        write_reg(REG_RADIUS, r);
        write_reg(REG_DISC_SHAPE, d);
        write_reg(REG_PADDED_WIDTH, w);
        write_reg(REG_PADDED_HEIGHT, h);
    endtask

    // Offers one pixel, with random idle cycles ahead of it, until it transfers.
    task automatic send_pixel(logic [PIX_W-1:0] pix, bit fs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            pixel = $urandom;
            frame_start = $urandom;
            @(negedge clk);
        end
        in_valid = 1'b1;
        pixel = pix;
        frame_start = fs;
        do @(posedge clk); while (in_stall);
        sb.note_pixel(pix, fs);
        pixels_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Sends one padded frame; pattern 0 random, 1 a zero at every third pixel and PIX_MAX between.
    task automatic send_frame(int unsigned w, int unsigned h, int pattern, bit restart_mid);
        int unsigned n;
        bit fs;
        n = w * h;
        frames_sent++;
        for (int unsigned i = 0; i < n; i++)
        begin
            fs = (i == 0) || (restart_mid && $urandom_range(99) < 2);
            if (pattern == 1)
                send_pixel((i % 3 == 0) ? 8'h00 : PIX_MAX, fs);
            else
                send_pixel($urandom, fs);
        end
    endtask

    initial
    begin
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int random_pixels;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        pixel = '0;
        frame_start = 1'b0;
        out_stall = 1'b0;
        hold_request = 1'b0;
        idle_cycles = 0;
        pixels_sent = 0;
        frames_sent = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset geometry, single-pixel window, extremes and degenerate sizes.
        send_pixel(8'h00, 1'b1);
        send_pixel(PIX_MAX, 1'b0);
        configure(0, 0, 4, 2);
        send_frame(4, 2, 1, 0);
        configure(1, 1, 5, 4);
        send_frame(5, 4, 1, 0);
        configure(7, 1, 16, 15);
        send_frame(16, 15, 0, 0);
        configure(0, 1, 0, 3);
        send_frame(1, 3, 0, 0);
        configure(2, 0, 4, 8);
        send_frame(4, 8, 0, 0);

        // Saturated sizes: the start of an oversized frame in each direction.
        configure(0, 0, 2047, 1);
        for (int i = 0; i < 30; i++)
            send_pixel($urandom, i == 0);
        configure(0, 0, 1, 2047);
        for (int i = 0; i < 30; i++)
            send_pixel($urandom, i == 0);

        // Random frames in three idle regimes; the first also holds the receiver off.
        random_pixels = 0;
        for (int regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 35 : (regime == 1) ? 87 : 0;
            recv_idle_pct = (regime == 0) ? 87 : (regime == 1) ? 35 : 0;
            if (regime == 0)
            begin
                configure(1, 0, 12, 10);
                hold_request = 1'b1;
                send_frame(12, 10, 0, 0);
            end
            while (random_pixels < 100 * (regime + 1))
            begin
                r = $urandom_range(0, 4);
                w = 2 * r + $urandom_range(1, 10);
                h = 2 * r + $urandom_range(1, 5);
                configure(r, $urandom_range(0, 1), w, h);
                send_frame(w, h, 0, $urandom_range(0, 3) == 0);
                random_pixels += w * h;
                if ($urandom_range(0, 2) == 0)
                begin
                    send_frame(w, h, 0, 0);
                    random_pixels += w * h;
                end
            end
        end

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Covered %0d pixels in %0d frames and checked %0d eroded pixels,",
                 pixels_sent, frames_sent, sb.results_seen);
        $display("radius 0 to 7, disc and square windows, degenerate and saturated sizes.");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* grayscale_min_filter.f */
hw/rtl/gmf_pkg.sv
hw/rtl/gmf_ram.sv
hw/rtl/gmf_front.sv
hw/rtl/gmf_queue.sv
hw/rtl/gmf_back.sv
hw/rtl/grayscale_min_filter.sv
tb/tb_grayscale_min_filter.sv
